/* design/afr_pkg.sv */
// ----------------------------------------------------------------------------
// afr_pkg: shared types and constants of the aspect-fit rectangle calculator
// Field widths, pipeline stage counts, fit mode and register codes, beat
// structs and the signed 32-bit saturation helper.
// ----------------------------------------------------------------------------
package afr_pkg;

  localparam int FRAC_BITS    = 16;
  localparam int DW           = 32;            // field width
  localparam int DVD_W        = 2 * DW;        // divider dividend / quotient width
  localparam int DIV_STEP     = 4;             // quotient bits per divider stage
  localparam int DIV_STAGES   = DVD_W / DIV_STEP;
  localparam int FRONT_STAGES = 5;
  localparam int BACK_STAGES  = 3;
  localparam int PIPE_STAGES  = FRONT_STAGES + DIV_STAGES + BACK_STAGES;
  localparam int IN_W         = 6 * DW;
  localparam int OUT_W        = 8 * DW;
  localparam int ADDR_W       = 5;

  localparam logic signed [DW-1:0] POS_RESET = 32'sd32768;

  typedef enum logic [2:0] {
    FIT_FILL       = 3'd0,
    FIT_CONTAIN    = 3'd1,
    FIT_COVER      = 3'd2,
    FIT_NONE       = 3'd3,
    FIT_SCALE_DOWN = 3'd4
  } fit_mode_e;

  typedef enum logic [2:0] {
    REG_FIT_MODE    = 3'd0,
    REG_POS_X_KIND  = 3'd1,
    REG_POS_X_VALUE = 3'd2,
    REG_POS_Y_KIND  = 3'd3,
    REG_POS_Y_VALUE = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic [2:0]           fit_mode;
    logic                 pos_x_kind;
    logic signed [DW-1:0] pos_x_value;
    logic                 pos_y_kind;
    logic signed [DW-1:0] pos_y_value;
  } afr_cfg_t;

  typedef struct packed {
    logic [DW-1:0]        img_width;
    logic [DW-1:0]        img_height;
    logic signed [DW-1:0] box_x;
    logic signed [DW-1:0] box_y;
    logic [DW-1:0]        box_width;
    logic [DW-1:0]        box_height;
  } afr_in_t;

  // travels alongside the main divider
  typedef struct packed {
    logic [DW-1:0]        img_w;
    logic [DW-1:0]        img_h;
    logic [DW-1:0]        box_w;
    logic [DW-1:0]        box_h;
    logic signed [DW-1:0] box_x;
    logic signed [DW-1:0] box_y;
    fit_mode_e            mode;
    logic                 empty;
    logic                 lim;      // limiting axis is horizontal
  } afr_side_t;

  typedef struct packed {
    logic signed [DW-1:0] src_left;
    logic signed [DW-1:0] src_top;
    logic [DW-1:0]        src_w;
    logic [DW-1:0]        src_h;
    logic signed [DW-1:0] dst_left;
    logic signed [DW-1:0] dst_top;
    logic [DW-1:0]        dst_w;
    logic [DW-1:0]        dst_h;
    logic                 is_empty;
  } afr_out_t;

  function automatic logic signed [DW-1:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (v < -66'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return v[DW-1:0];
    end
  endfunction

endpackage

/* design/afr_div.sv */
// ----------------------------------------------------------------------------
// afr_div: pipelined unsigned divider
// Restoring division of a 64-bit dividend by a 32-bit divisor, a few quotient
// bits per stage, with a sideband carried in step with the operands.
// ----------------------------------------------------------------------------
module afr_div #(
  parameter int SIDE_W = 1
) (
  input  logic                            clk,
  input  logic [afr_pkg::DIV_STAGES-1:0]  adv,
  input  logic [afr_pkg::DVD_W-1:0]       dvd,
  input  logic [afr_pkg::DW-1:0]          dvs,
  input  logic [SIDE_W-1:0]               side_in,
  output logic [afr_pkg::DVD_W-1:0]       quo,
  output logic                            rem_nz,
  output logic [SIDE_W-1:0]               side_out
);

  localparam int DW  = afr_pkg::DW;
  localparam int NW  = afr_pkg::DVD_W;
  localparam int NST = afr_pkg::DIV_STAGES;

  logic [DW-1:0]     r_q [NST];
  logic [NW-1:0]     n_q [NST];   // dividend bits shift out, quotient bits shift in
  logic [DW-1:0]     d_q [NST];
  logic [SIDE_W-1:0] s_q [NST];

  function automatic logic [DW+NW-1:0] div_steps(input logic [DW-1:0] r,
                                                 input logic [NW-1:0] n,
                                                 input logic [DW-1:0] d);
    logic [DW:0]   t;
    logic [DW-1:0] rr;
    logic [NW-1:0] nn;
    rr = r;
    nn = n;
    for (int k = 0; k < afr_pkg::DIV_STEP; k++) begin
      t = {rr, nn[NW-1]};
      if (t >= {1'b0, d}) begin
        rr = DW'(t - {1'b0, d});
        nn = {nn[NW-2:0], 1'b1};
      end else begin
        rr = t[DW-1:0];
        nn = {nn[NW-2:0], 1'b0};
      end
    end
    return {rr, nn};
  endfunction

  for (genvar g = 0; g < NST; g++) begin : g_stage
    if (g == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (adv[g]) begin
          {r_q[g], n_q[g]} <= div_steps('0, dvd, dvs);
          d_q[g]           <= dvs;
          s_q[g]           <= side_in;
        end
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (adv[g]) begin
          {r_q[g], n_q[g]} <= div_steps(r_q[g-1], n_q[g-1], d_q[g-1]);
          d_q[g]           <= d_q[g-1];
          s_q[g]           <= s_q[g-1];
        end
      end
    end
  end

  assign quo      = n_q[NST-1];
  assign rem_nz   = |r_q[NST-1];
  assign side_out = s_q[NST-1];

endmodule

/* design/afr_front.sv */
// ----------------------------------------------------------------------------
// afr_front: input register, aspect products, limiting axis and divider setup
// Five stages: capture, cross products, compare and select, pixel offset
// products for cover, sign/magnitude split.
// ----------------------------------------------------------------------------
module afr_front (
  input  logic                              clk,
  input  logic [afr_pkg::FRONT_STAGES-1:0]  adv,
  input  afr_pkg::afr_in_t                  in_beat,
  input  afr_pkg::afr_cfg_t                 cfg,
  output logic [afr_pkg::DVD_W-1:0]         main_dvd,
  output logic [afr_pkg::DW-1:0]            main_dvs,
  output afr_pkg::afr_side_t                main_side,
  output logic [afr_pkg::DVD_W-1:0]         px_mag,
  output logic                              px_neg,
  output logic [afr_pkg::DVD_W-1:0]         py_mag,
  output logic                              py_neg,
  output logic [afr_pkg::DW-1:0]            pix_dvs
);

  localparam int DW = afr_pkg::DW;
  localparam int NW = afr_pkg::DVD_W;

  afr_pkg::afr_in_t   a_in, b_in;
  logic [NW-1:0]      b_p1, b_p2;        // box_w*img_h, box_h*img_w
  logic               b_empty;
  afr_pkg::fit_mode_e b_mode, b_mode_next;

  logic               c_lim_next;
  logic [NW-1:0]      c_dvd_next, c_dvd;
  logic [DW-1:0]      c_dvs_next, c_dvs, c_num_next, c_num;
  afr_pkg::afr_side_t c_side, d_side, e_side;

  logic signed [NW-1:0] pos_x_ext, pos_y_ext, num_ext;
  logic signed [NW-1:0] d_px, d_py;
  logic [NW-1:0]        d_dvd, e_dvd;
  logic [DW-1:0]        d_dvs, e_dvs;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      a_in <= in_beat;
    end
  end

  // scale-down picks none when the image fits, else contain; unused codes fill
  always_comb begin
    unique case (cfg.fit_mode)
      afr_pkg::FIT_CONTAIN: b_mode_next = afr_pkg::FIT_CONTAIN;
      afr_pkg::FIT_COVER:   b_mode_next = afr_pkg::FIT_COVER;
      afr_pkg::FIT_NONE:    b_mode_next = afr_pkg::FIT_NONE;
      afr_pkg::FIT_SCALE_DOWN: begin
        b_mode_next = (a_in.img_width <= a_in.box_width &&
                       a_in.img_height <= a_in.box_height) ?
                      afr_pkg::FIT_NONE : afr_pkg::FIT_CONTAIN;
      end
      default: b_mode_next = afr_pkg::FIT_FILL;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      b_p1    <= NW'(a_in.box_width) * NW'(a_in.img_height);
      b_p2    <= NW'(a_in.box_height) * NW'(a_in.img_width);
      b_in    <= a_in;
      b_empty <= (a_in.img_width == '0) || (a_in.img_height == '0) ||
                 (a_in.box_width == '0) || (a_in.box_height == '0);
      b_mode  <= b_mode_next;
    end
  end

  always_comb begin
    if (b_mode == afr_pkg::FIT_COVER) begin
      c_lim_next = (b_p1 >= b_p2);
      c_dvd_next = c_lim_next ? b_p2 : b_p1;
      c_dvs_next = c_lim_next ? b_in.box_width : b_in.box_height;
      c_num_next = c_lim_next ? b_in.img_width : b_in.img_height;
    end else begin
      c_lim_next = (b_p1 <= b_p2);
      c_dvd_next = c_lim_next ? b_p1 : b_p2;
      c_dvs_next = c_lim_next ? b_in.img_width : b_in.img_height;
      c_num_next = b_in.img_width;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      c_dvd        <= c_dvd_next;
      c_dvs        <= c_dvs_next;
      c_num        <= c_num_next;
      c_side.img_w <= b_in.img_width;
      c_side.img_h <= b_in.img_height;
      c_side.box_w <= b_in.box_width;
      c_side.box_h <= b_in.box_height;
      c_side.box_x <= b_in.box_x;
      c_side.box_y <= b_in.box_y;
      c_side.mode  <= b_mode;
      c_side.empty <= b_empty;
      c_side.lim   <= c_lim_next;
    end
  end

  assign pos_x_ext = NW'(cfg.pos_x_value);
  assign pos_y_ext = NW'(cfg.pos_y_value);
  assign num_ext   = $signed(NW'(c_num));

  // |pos * num| < 2^63, so the 64-bit product is exact
  always_ff @(posedge clk) begin
    if (adv[3]) begin
      d_px   <= pos_x_ext * num_ext;
      d_py   <= pos_y_ext * num_ext;
      d_dvd  <= c_dvd;
      d_dvs  <= c_dvs;
      d_side <= c_side;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      px_neg <= d_px[NW-1];
      px_mag <= d_px[NW-1] ? NW'(-d_px) : NW'(d_px);
      py_neg <= d_py[NW-1];
      py_mag <= d_py[NW-1] ? NW'(-d_py) : NW'(d_py);
      e_dvd  <= d_dvd;
      e_dvs  <= d_dvs;
      e_side <= d_side;
    end
  end

  assign main_dvd  = e_dvd;
  assign main_dvs  = e_dvs;
  assign main_side = e_side;
  assign pix_dvs   = e_dvs;

endmodule

/* design/afr_back.sv */
// ----------------------------------------------------------------------------
// afr_back: rectangle assembly after the dividers
// Three stages: sizes and free space, position products, offsets with
// saturation into the result register.
// ----------------------------------------------------------------------------
module afr_back #(
  parameter int FRAC_BITS = afr_pkg::FRAC_BITS
) (
  input  logic                             clk,
  input  logic [afr_pkg::BACK_STAGES-1:0]  adv,
  input  afr_pkg::afr_cfg_t                cfg,
  input  logic [afr_pkg::DVD_W-1:0]        main_quo,
  input  afr_pkg::afr_side_t               side,
  input  logic [afr_pkg::DVD_W-1:0]        px_quo,
  input  logic                             px_rnz,
  input  logic                             px_neg,
  input  logic [afr_pkg::DVD_W-1:0]        py_quo,
  input  logic                             py_rnz,
  input  logic                             py_neg,
  output afr_pkg::afr_out_t                res
);

  localparam int DW = afr_pkg::DW;
  localparam int NW = afr_pkg::DVD_W;

  logic [DW-1:0]        sw_n, sh_n, dw_n, dh_n;
  logic signed [DW:0]   ax_n, ay_n;
  logic [DW-1:0]        f_sw, f_sh, f_dw, f_dh, g_sw, g_sh, g_dw, g_dh;
  logic signed [DW:0]   f_ax, f_ay;
  logic signed [DW-1:0] f_pix_x, f_pix_y, g_pix_x, g_pix_y;
  logic signed [DW-1:0] f_bx, f_by, g_bx, g_by;
  afr_pkg::fit_mode_e   f_mode, g_mode;
  logic                 f_empty, g_empty;
  logic signed [DW*2:0] g_prx, g_pry;
  logic signed [DW*2:0] offx, offy;
  logic signed [65:0]   dlx, dty;
  afr_pkg::afr_out_t    res_next;

  // floor of a signed quotient given as magnitude, remainder flag and sign
  function automatic logic signed [DW-1:0] pix_sat(input logic [NW-1:0] q,
                                                   input logic rnz,
                                                   input logic neg);
    logic [NW:0] t;
    t = {1'b0, q} + (NW+1)'(rnz);
    if (!neg) begin
      return (q > NW'(32'h7FFFFFFF)) ? 32'sh7FFFFFFF : q[DW-1:0];
    end else begin
      return (t > (NW+1)'(33'h80000000)) ? 32'sh80000000 : (~t[DW-1:0]) + 32'd1;
    end
  endfunction

  always_comb begin
    sw_n = side.img_w;
    sh_n = side.img_h;
    dw_n = side.box_w;
    dh_n = side.box_h;
    ax_n = '0;
    ay_n = '0;
    unique case (side.mode)
      afr_pkg::FIT_CONTAIN: begin
        if (side.lim) begin
          dh_n = main_quo[DW-1:0];
        end else begin
          dw_n = main_quo[DW-1:0];
        end
        ax_n = $signed({1'b0, side.box_w}) - $signed({1'b0, dw_n});
        ay_n = $signed({1'b0, side.box_h}) - $signed({1'b0, dh_n});
      end
      afr_pkg::FIT_COVER: begin
        if (side.lim) begin
          sh_n = main_quo[DW-1:0];
        end else begin
          sw_n = main_quo[DW-1:0];
        end
        ax_n = $signed({1'b0, side.img_w}) - $signed({1'b0, sw_n});
        ay_n = $signed({1'b0, side.img_h}) - $signed({1'b0, sh_n});
      end
      afr_pkg::FIT_NONE: begin
        dw_n = side.img_w;
        dh_n = side.img_h;
        ax_n = $signed({1'b0, side.box_w}) - $signed({1'b0, side.img_w});
        ay_n = $signed({1'b0, side.box_h}) - $signed({1'b0, side.img_h});
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      f_sw    <= sw_n;
      f_sh    <= sh_n;
      f_dw    <= dw_n;
      f_dh    <= dh_n;
      f_ax    <= ax_n;
      f_ay    <= ay_n;
      f_pix_x <= pix_sat(px_quo, px_rnz, px_neg);
      f_pix_y <= pix_sat(py_quo, py_rnz, py_neg);
      f_bx    <= side.box_x;
      f_by    <= side.box_y;
      f_mode  <= side.mode;
      f_empty <= side.empty;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      g_prx   <= (DW*2+1)'(f_ax) * (DW*2+1)'(cfg.pos_x_value);
      g_pry   <= (DW*2+1)'(f_ay) * (DW*2+1)'(cfg.pos_y_value);
      g_sw    <= f_sw;
      g_sh    <= f_sh;
      g_dw    <= f_dw;
      g_dh    <= f_dh;
      g_pix_x <= f_pix_x;
      g_pix_y <= f_pix_y;
      g_bx    <= f_bx;
      g_by    <= f_by;
      g_mode  <= f_mode;
      g_empty <= f_empty;
    end
  end

  // arithmetic shift rounds toward minus infinity
  assign offx = g_prx >>> FRAC_BITS;
  assign offy = g_pry >>> FRAC_BITS;
  assign dlx  = 66'(g_bx) + (cfg.pos_x_kind ? 66'(cfg.pos_x_value) : 66'(offx));
  assign dty  = 66'(g_by) + (cfg.pos_y_kind ? 66'(cfg.pos_y_value) : 66'(offy));

  always_comb begin
    res_next.src_left = '0;
    res_next.src_top  = '0;
    res_next.src_w    = g_sw;
    res_next.src_h    = g_sh;
    res_next.dst_left = g_bx;
    res_next.dst_top  = g_by;
    res_next.dst_w    = g_dw;
    res_next.dst_h    = g_dh;
    res_next.is_empty = 1'b0;
    unique case (g_mode)
      afr_pkg::FIT_CONTAIN, afr_pkg::FIT_NONE: begin
        res_next.dst_left = afr_pkg::sat32(dlx);
        res_next.dst_top  = afr_pkg::sat32(dty);
      end
      afr_pkg::FIT_COVER: begin
        res_next.src_left = cfg.pos_x_kind ? g_pix_x : afr_pkg::sat32(66'(offx));
        res_next.src_top  = cfg.pos_y_kind ? g_pix_y : afr_pkg::sat32(66'(offy));
      end
      default: begin
      end
    endcase
    if (g_empty) begin
      res_next          = '0;
      res_next.is_empty = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      res <= res_next;
    end
  end

endmodule

/* design/aspect_fit_rect_calculator.sv */
// ----------------------------------------------------------------------------
// aspect_fit_rect_calculator: object-fit / object-position layout
//
//   channel  dir  beat contents
//   s_*      in   image size and container rectangle, Q16.16
//   m_*      out  source crop and destination rectangle, empty flag
//   apb      in   fit mode and per-axis position registers
//
// One beat per cycle sustained while the output is not stalled.
// The pipeline runs through the front stages, the 16-stage dividers (4 quotient bits per stage) and the back stages.
// Every stage has its own valid bit and loads when empty or when the next
// stage moves, so bubbles close up while the output waits.
// Reset (rst, synchronous) clears the valid bits and returns the configuration registers to their defaults.
// ----------------------------------------------------------------------------
module aspect_fit_rect_calculator #(
  parameter int FRAC_BITS = afr_pkg::FRAC_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // img_width, img_height, box_x, box_y, box_width, box_height
  input  logic [afr_pkg::IN_W-1:0]     s_tdata,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // src_left, src_top, src_w, src_h, dst_left, dst_top, dst_w, dst_h
  output logic [afr_pkg::OUT_W-1:0]    m_tdata,
  // is_empty
  output logic [0:0]                   m_tuser,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [afr_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  localparam int DW  = afr_pkg::DW;
  localparam int N   = afr_pkg::PIPE_STAGES;
  localparam int NF  = afr_pkg::FRONT_STAGES;
  localparam int ND  = afr_pkg::DIV_STAGES;
  localparam int NB  = afr_pkg::BACK_STAGES;
  localparam int NW  = afr_pkg::DVD_W;
  localparam int SDW = $bits(afr_pkg::afr_side_t);

  afr_pkg::afr_cfg_t  cfg;
  afr_pkg::afr_in_t   in_beat;
  afr_pkg::afr_side_t main_side, div_side;
  afr_pkg::afr_out_t  res;

  logic [N-1:0]  v, adv;
  logic [NW-1:0] main_dvd, px_mag, py_mag, main_quo, px_quo, py_quo;
  logic [DW-1:0] main_dvs, pix_dvs;
  logic          px_neg, py_neg, px_neg_d, py_neg_d;
  logic          main_rnz, px_rnz, py_rnz;
  logic          cfg_wr;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fit_mode    <= afr_pkg::FIT_FILL;
      cfg.pos_x_kind  <= 1'b0;
      cfg.pos_x_value <= afr_pkg::POS_RESET;
      cfg.pos_y_kind  <= 1'b0;
      cfg.pos_y_value <= afr_pkg::POS_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        afr_pkg::REG_FIT_MODE:    cfg.fit_mode    <= pwdata[2:0];
        afr_pkg::REG_POS_X_KIND:  cfg.pos_x_kind  <= pwdata[0];
        afr_pkg::REG_POS_X_VALUE: cfg.pos_x_value <= pwdata;
        afr_pkg::REG_POS_Y_KIND:  cfg.pos_y_kind  <= pwdata[0];
        afr_pkg::REG_POS_Y_VALUE: cfg.pos_y_value <= pwdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      afr_pkg::REG_FIT_MODE:    prdata = 32'(cfg.fit_mode);
      afr_pkg::REG_POS_X_KIND:  prdata = 32'(cfg.pos_x_kind);
      afr_pkg::REG_POS_X_VALUE: prdata = cfg.pos_x_value;
      afr_pkg::REG_POS_Y_KIND:  prdata = 32'(cfg.pos_y_kind);
      afr_pkg::REG_POS_Y_VALUE: prdata = cfg.pos_y_value;
      default:                  prdata = '0;
    endcase
  end

  // per-stage valid and advance
  assign adv[N-1] = ~v[N-1] | m_tready;
  for (genvar k = 0; k < N - 1; k++) begin : g_adv
    assign adv[k] = ~v[k] | adv[k+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int k = 0; k < N; k++) begin
        if (adv[k]) begin
          v[k] <= (k == 0) ? s_tvalid : v[(k == 0) ? 0 : k-1];
        end
      end
    end
  end

  assign s_tready = adv[0];
  assign m_tvalid = v[N-1];

  assign in_beat.img_width  = s_tdata[0*DW +: DW];
  assign in_beat.img_height = s_tdata[1*DW +: DW];
  assign in_beat.box_x      = s_tdata[2*DW +: DW];
  assign in_beat.box_y      = s_tdata[3*DW +: DW];
  assign in_beat.box_width  = s_tdata[4*DW +: DW];
  assign in_beat.box_height = s_tdata[5*DW +: DW];

  afr_front u_front (
    .clk       (clk),
    .adv       (adv[NF-1:0]),
    .in_beat   (in_beat),
    .cfg       (cfg),
    .main_dvd  (main_dvd),
    .main_dvs  (main_dvs),
    .main_side (main_side),
    .px_mag    (px_mag),
    .px_neg    (px_neg),
    .py_mag    (py_mag),
    .py_neg    (py_neg),
    .pix_dvs   (pix_dvs)
  );

  afr_div #(.SIDE_W(SDW)) u_div_main (
    .clk      (clk),
    .adv      (adv[NF +: ND]),
    .dvd      (main_dvd),
    .dvs      (main_dvs),
    .side_in  (main_side),
    .quo      (main_quo),
    .rem_nz   (main_rnz),
    .side_out (div_side)
  );

  afr_div #(.SIDE_W(1)) u_div_px (
    .clk      (clk),
    .adv      (adv[NF +: ND]),
    .dvd      (px_mag),
    .dvs      (pix_dvs),
    .side_in  (px_neg),
    .quo      (px_quo),
    .rem_nz   (px_rnz),
    .side_out (px_neg_d)
  );

  afr_div #(.SIDE_W(1)) u_div_py (
    .clk      (clk),
    .adv      (adv[NF +: ND]),
    .dvd      (py_mag),
    .dvs      (pix_dvs),
    .side_in  (py_neg),
    .quo      (py_quo),
    .rem_nz   (py_rnz),
    .side_out (py_neg_d)
  );

  // fit divisions are exact floors of nonnegative values; remainder unused
  afr_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk      (clk),
    .adv      (adv[NF+ND +: NB]),
    .cfg      (cfg),
    .main_quo (main_quo),
    .side     (div_side),
    .px_quo   (px_quo),
    .px_rnz   (px_rnz | (main_rnz & 1'b0)),
    .px_neg   (px_neg_d),
    .py_quo   (py_quo),
    .py_rnz   (py_rnz),
    .py_neg   (py_neg_d),
    .res      (res)
  );

  assign m_tdata = {res.dst_h, res.dst_w, res.dst_top, res.dst_left,
                    res.src_h, res.src_w, res.src_top, res.src_left};
  assign m_tuser = res.is_empty;

endmodule

/* design/afr_checker.sv */
// ----------------------------------------------------------------------------
// afr_checker: port-level checks of the aspect-fit rectangle calculator
// Watches the result channel and the configuration port; bound to the top.
// ----------------------------------------------------------------------------
module afr_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       m_tvalid,
  input logic                       m_tready,
  input logic [afr_pkg::OUT_W-1:0]  m_tdata,
  input logic [0:0]                 m_tuser,
  input logic                       pready
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result beat changed while stalled");

  // nothing comes out right after reset
  a_rst_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("result valid after reset");

  // an empty layout carries all-zero rectangles
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata == '0)
    else $error("empty beat with nonzero rectangles");

  // configuration never waits
  a_pready: assert property (@(posedge clk)
    pready)
    else $error("pready low");

endmodule

bind aspect_fit_rect_calculator afr_checker u_afr_checker (.*);

/* dv/tb_aspect_fit_rect_calculator.sv */
// ----------------------------------------------------------------------------
// tb_aspect_fit_rect_calculator: layout calculator stream test
// Drives image/container beats through the stream input, predicts each
// crop and destination rectangle in order and compares every output beat.
// Fit mode and position registers are rewritten over several phases.
// ----------------------------------------------------------------------------
module tb_aspect_fit_rect_calculator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY   = 24;
  localparam int WDOG_MAX  = 20000;
  localparam int N_RANDOM  = 1300;

  typedef struct {
    logic [2:0]         mode;
    bit                 x_pix;
    logic signed [31:0] x_val;
    bit                 y_pix;
    logic signed [31:0] y_val;
  } layout_cfg_t;

  // floor(a / d), d > 0
  function automatic longint fdiv(longint a, longint d);
    longint q;
    q = a / d;
    if ((a % d != 0) && (a < 0)) q = q - 1;
    return q;
  endfunction

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic longint axis_shift(bit pix, longint val, longint avail);
    if (pix) return val;
    return fdiv(avail * val, 64'sd1 << afr_pkg::FRAC_BITS);
  endfunction

  function automatic afr_pkg::afr_out_t layout_rects(layout_cfg_t c, afr_pkg::afr_in_t a);
    afr_pkg::afr_out_t r;
    longint iw, ih, cw, ch, bx, by, sl, st, dl, dt, sw, sh, dw, dh, num, den;
    longint unsigned uiw, uih, ucw, uch;   // size products need all 64 bits
    logic [2:0] m;
    iw = a.img_width; ih = a.img_height; cw = a.box_width; ch = a.box_height;
    uiw = a.img_width; uih = a.img_height; ucw = a.box_width; uch = a.box_height;
    bx = a.box_x; by = a.box_y;
    r = '0;
    if (iw == 0 || ih == 0 || cw == 0 || ch == 0) begin
      r.is_empty = 1'b1;
      return r;
    end
    sl = 0; st = 0; dl = bx; dt = by; sw = iw; sh = ih; dw = cw; dh = ch;
    m = c.mode;
    if (m == afr_pkg::FIT_SCALE_DOWN) begin
      m = (iw <= cw && ih <= ch) ? afr_pkg::FIT_NONE : afr_pkg::FIT_CONTAIN;
    end
    if (m == afr_pkg::FIT_CONTAIN) begin
      if (ucw * uih <= uch * uiw) begin
        dh = longint'(uih * ucw / uiw);
      end else begin
        dw = longint'(uiw * uch / uih);
      end
      dl = bx + axis_shift(c.x_pix, c.x_val, cw - dw);
      dt = by + axis_shift(c.y_pix, c.y_val, ch - dh);
    end else if (m == afr_pkg::FIT_COVER) begin
      if (ucw * uih >= uch * uiw) begin
        num = iw; den = cw; sh = longint'(uch * uiw / ucw);
      end else begin
        num = ih; den = ch; sw = longint'(ucw * uih / uch);
      end
      sl = c.x_pix ? fdiv(c.x_val * num, den) : fdiv((iw - sw) * c.x_val, 65536);
      st = c.y_pix ? fdiv(c.y_val * num, den) : fdiv((ih - sh) * c.y_val, 65536);
    end else if (m == afr_pkg::FIT_NONE) begin
      dw = iw; dh = ih;
      dl = bx + axis_shift(c.x_pix, c.x_val, cw - iw);
      dt = by + axis_shift(c.y_pix, c.y_val, ch - ih);
    end
    r.src_left = clamp32(sl); r.src_top = clamp32(st);
    r.src_w = sw[31:0]; r.src_h = sh[31:0];
    r.dst_left = clamp32(dl); r.dst_top = clamp32(dt);
    r.dst_w = dw[31:0]; r.dst_h = dh[31:0];
    return r;
  endfunction

  class rect_scoreboard;
    layout_cfg_t       cfg;
    afr_pkg::afr_out_t pending[$];
    int                errors;

    function void note_request(afr_pkg::afr_in_t a);
      pending.push_back(layout_rects(cfg, a));
    endfunction

    function void check_result(afr_pkg::afr_out_t got);
      afr_pkg::afr_out_t exp;
      if (pending.size() == 0) begin
        $display("%0t: unexpected beat %h", $realtime, got);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.src_left !== exp.src_left) report("src_left", exp.src_left, got.src_left);
      if (got.src_top !== exp.src_top) report("src_top", exp.src_top, got.src_top);
      if (got.src_w !== exp.src_w) report("src_w", exp.src_w, got.src_w);
      if (got.src_h !== exp.src_h) report("src_h", exp.src_h, got.src_h);
      if (got.dst_left !== exp.dst_left) report("dst_left", exp.dst_left, got.dst_left);
      if (got.dst_top !== exp.dst_top) report("dst_top", exp.dst_top, got.dst_top);
      if (got.dst_w !== exp.dst_w) report("dst_w", exp.dst_w, got.dst_w);
      if (got.dst_h !== exp.dst_h) report("dst_h", exp.dst_h, got.dst_h);
      if (got.is_empty !== exp.is_empty) begin
        report("is_empty", 32'(exp.is_empty), 32'(got.is_empty));
      end
    endfunction

    function void report(string f, logic [31:0] e, logic [31:0] g);
      $display("%0t: %s expected %h actual %h", $realtime, f, e, g);
      errors++;
    endfunction
  endclass

  logic clk, rst;
  logic s_tvalid, s_tready, m_tvalid, m_tready;
  logic [afr_pkg::IN_W-1:0] s_tdata;
  logic [afr_pkg::OUT_W-1:0] m_tdata;
  logic [0:0] m_tuser;
  logic psel, penable, pwrite, pready;
  logic [afr_pkg::ADDR_W-1:0] paddr;
  logic [31:0] pwdata, prdata;

  aspect_fit_rect_calculator dut (.*);

  rect_scoreboard sb;
  bit  quiet;       // no idling in the final stretch
  bit  hold_req;    // long receiver hold-off
  int  idle_cycles;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // tdata packs the first field in the lowest bits
  function automatic logic [afr_pkg::IN_W-1:0] pack_in(afr_pkg::afr_in_t a);
    return {a.box_height, a.box_width, a.box_y, a.box_x, a.img_height, a.img_width};
  endfunction

  function automatic afr_pkg::afr_out_t unpack_out(logic [afr_pkg::OUT_W-1:0] d, logic e);
    afr_pkg::afr_out_t r;
    r.src_left = d[31:0];    r.src_top = d[63:32];
    r.src_w = d[95:64];      r.src_h = d[127:96];
    r.dst_left = d[159:128]; r.dst_top = d[191:160];
    r.dst_w = d[223:192];    r.dst_h = d[255:224];
    r.is_empty = e;
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) sb.check_result(unpack_out(m_tdata, m_tuser[0]));
      if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG_MAX) begin
        $display("tb_aspect_fit_rect_calculator: errors");
        $finish;
      end
    end
  end

  // receiver: random stall bursts, plus a long hold-off on request
  initial begin
    int n;
    m_tready = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_req) begin
        m_tready = 0;
        repeat (200) @(negedge clk);
        hold_req = 0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        m_tready = 0;
        n = $urandom_range(1, 5);
        repeat (n) @(negedge clk);
      end else begin
        m_tready = 1;
        @(negedge clk);
      end
    end
  end

  // tvalid stays high between back-to-back beats unless a random gap is inserted; callers drop it when done
  task automatic send_beat(afr_pkg::afr_in_t a);
    int n;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 0;
      n = $urandom_range(1, 5);
      repeat (n) @(negedge clk);
    end
    s_tdata <= pack_in(a);
    s_tvalid <= 1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_request(a);
    @(negedge clk);
  endtask

  task automatic apb_write(afr_pkg::reg_idx_e idx, logic [31:0] v);
    psel <= 1; pwrite <= 1; penable <= 0;
    paddr <= afr_pkg::ADDR_W'(4 * idx); pwdata <= v;
    @(negedge clk);
    penable <= 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_layout(logic [2:0] m, bit xp, logic [31:0] xv, bit yp, logic [31:0] yv);
    apb_write(afr_pkg::REG_FIT_MODE, 32'(m));
    apb_write(afr_pkg::REG_POS_X_KIND, 32'(xp));
    apb_write(afr_pkg::REG_POS_X_VALUE, xv);
    apb_write(afr_pkg::REG_POS_Y_KIND, 32'(yp));
    apb_write(afr_pkg::REG_POS_Y_VALUE, yv);
    psel <= 0; penable <= 0; pwrite <= 0;
    sb.cfg = '{m, xp, xv, yp, yv};
  endtask

  task automatic drain();
    s_tvalid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  function automatic logic [31:0] rand_size();
    case ($urandom_range(0, 5))
      0: return $urandom_range(1, 4) << 16;
      1: return $urandom_range(1, 2000) << 16;
      2: return $urandom_range(1, 32'h00FF_FFFF);
      3: return $urandom;
      4: return 32'hFFFF_FFFF - $urandom_range(0, 3);
      default: return $urandom_range(0, 2) == 0 ? 32'd0 : $urandom_range(1, 65536);
    endcase
  endfunction

  function automatic logic [31:0] rand_pos(bit pix);
    case ($urandom_range(0, 4))
      0: return pix ? ($urandom_range(0, 400) - 200) << 16 : $urandom_range(0, 65536);
      1: return 32'h8000_0000;
      2: return 32'h7FFF_FFFF;
      3: return $urandom;
      default: return $urandom_range(0, 2) * 32768;
    endcase
  endfunction

  function automatic afr_pkg::afr_in_t rand_req();
    afr_pkg::afr_in_t a;
    a.img_width = rand_size(); a.img_height = rand_size();
    a.box_width = rand_size(); a.box_height = rand_size();
    a.box_x = $urandom_range(0, 1) ? $urandom : ($urandom_range(0, 200) - 100) << 16;
    a.box_y = $urandom_range(0, 1) ? $urandom : ($urandom_range(0, 200) - 100) << 16;
    return a;
  endfunction

  initial begin
    afr_pkg::afr_in_t a;
    bit xp, yp;
    sb = new();
    sb.cfg = '{afr_pkg::FIT_FILL, 0, afr_pkg::POS_RESET, 0, afr_pkg::POS_RESET};
    rst = 1; s_tvalid = 0; s_tdata = '0;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    quiet = 0; hold_req = 0; idle_cycles = 0;
    repeat (10) @(negedge clk);
    rst = 0;

    // directed: reset settings, then each mode code with extremes, then zero sizes
    for (int m = 0; m < 8; m++) begin
      if (m > 0) begin
        drain();
        set_layout(m[2:0], m[0], m[1] ? 32'h8000_0000 : 32'h0001_0000,
                   m[2], m[0] ? 32'h7FFF_FFFF : 32'h0);
      end
      send_beat('{32'h0064_0000, 32'h0032_0000, 32'sh0, 32'sh0, 32'h00C8_0000, 32'h00C8_0000});
      send_beat('{32'h0032_0000, 32'h0064_0000, -32'sh0010_0000, 32'sh7FFF_FFFF,
                  32'h0010_0000, 32'h0064_0000});
      send_beat('{32'hFFFF_FFFF, 32'h1, 32'sh8000_0000, 32'sh8000_0000, 32'h1, 32'hFFFF_FFFF});
    end
    send_beat('{32'h0, 32'h0001_0000, 32'sh1, 32'sh1, 32'h0001_0000, 32'h0001_0000});
    send_beat('{32'h0001_0000, 32'h0001_0000, 32'sh1, 32'sh1, 32'h0001_0000, 32'h0});

    for (int phase = 0; phase < 13; phase++) begin
      drain();
      xp = $urandom_range(0, 1); yp = $urandom_range(0, 1);
      set_layout(phase < 10 ? 3'(phase % 5) : 3'($urandom_range(0, 7)), xp, rand_pos(xp),
                 yp, rand_pos(yp));
      if (phase == 3) hold_req = 1;
      if (phase == 12) quiet = 1;
      for (int i = 0; i < N_RANDOM / 13; i++) begin
        a = rand_req();
        send_beat(a);
      end
    end

    s_tvalid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
    if (sb.errors == 0) begin
      $display("tb_aspect_fit_rect_calculator: clean");
    end else begin
      $display("tb_aspect_fit_rect_calculator: errors");
    end
    $finish;
  end

endmodule
